[sv/mss_pkg.sv]
package mss_pkg;

  localparam int TEXT_W    = 12;
  localparam int PAUSE_W   = 16;
  localparam int SPEED_W   = 10;
  localparam int DELTA_W   = 16;
  localparam int OFFSET_W  = 13;
  localparam int PHASE_W   = 2;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // scaled time path: saturated multiplicand, product, quotient, remainder
  localparam int X_W    = 23;
  localparam int PROD_W = 26;
  localparam int QUO_W  = 17;
  localparam int REM_W  = 10;
  localparam int Q_W    = 13;

  localparam int MS_PER_S = 1000;

  // floor(p / 1000) = floor((p >> 3) * RECIP >> RECIP_SHIFT), exact for p < 2**26
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_WIDTH     = 3'd0,
    REG_BOX_WIDTH      = 3'd1,
    REG_PAUSE_MS       = 3'd2,
    REG_SCROLL_SPEED   = 3'd3,
    REG_ROLLOVER_SPEED = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } scaled_t;

  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] r;
  } pos_t;

endpackage

[sv/mss_scale.sv]
module mss_scale (
  input  logic                         clk,
  input  logic                         en,
  input  logic [mss_pkg::X_W-1:0]      x,
  input  logic [mss_pkg::SPEED_W-1:0]  speed,
  output mss_pkg::scaled_t             res
);
  import mss_pkg::*;

  logic [X_W+SPEED_W-1:0]   prod_full;
  logic [PROD_W-1:0]        prod_sat;
  logic [PROD_W-1:0]        prod2;
  logic [PROD_W-1:0]        prod3;
  logic [X_W+RECIP_W-1:0]   recip_full;
  logic [QUO_W-1:0]         quo3;
  logic [PROD_W:0]          quo_k;
  logic [PROD_W:0]          rem_full;

  always_comb begin
    prod_full = x * speed;
    if (|prod_full[X_W+SPEED_W-1:PROD_W]) begin
      prod_sat = '1;
    end else begin
      prod_sat = prod_full[PROD_W-1:0];
    end
  end

  assign recip_full = prod2[PROD_W-1:3] * RECIP;
  assign quo_k      = (PROD_W+1)'(quo3) * (PROD_W+1)'(MS_PER_S);
  assign rem_full   = (PROD_W+1)'(prod3) - quo_k;

  always_ff @(posedge clk) begin
    if (en) begin
      prod2   <= prod_sat;
      prod3   <= prod2;
      quo3    <= recip_full[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      res.quo <= quo3;
      res.rem <= rem_full[REM_W-1:0];
    end
  end

endmodule

[sv/marquee_scroll_sequencer_core.sv]
// Marquee scroll sequencer.
// tick channel: tick_valid/tick_stall with delta_ms, one transaction per time tick.
// result channel: result_valid/result_stall with offset, phase, active; exactly one
// result transaction per tick, in order.
// cfg channel: cfg_valid/cfg_ready with cfg_index/cfg_data; indexes past the last
// register are ignored. Write only while no tick is in flight.
// Ticks pass input, scaling and state stages. Unstalled throughput: one tick per
// cycle; the tick-to-tick dependency closes in the last stage through adders only,
// since position is kept as running quotient and remainder of elapsed*speed/1000.
// A register write sends one rescaling transaction down the same pipeline to rebuild
// those from the elapsed counter; it produces no result.
// Reset clears registers, phase (left pause) and elapsed time; pipeline empties.
// A stalled result freezes the whole pipeline and raises tick_stall in the same
// cycle; nothing is dropped.
module marquee_scroll_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_stall,
  input  logic [mss_pkg::DELTA_W-1:0]    delta_ms,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [mss_pkg::OFFSET_W-1:0]   offset,
  output logic [mss_pkg::PHASE_W-1:0]    phase,
  output logic                           active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mss_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import mss_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_LEFT_PAUSE   = 2'd0,
    PH_SCROLL_RIGHT = 2'd1,
    PH_RIGHT_PAUSE  = 2'd2,
    PH_ROLL_OVER    = 2'd3
  } phase_t;

  localparam logic [Q_W-1:0] Q_MAX = '1;

  logic en, tick_acc, cfg_acc;

  logic [TEXT_W-1:0]  text_width, box_width;
  logic [PAUSE_W-1:0] pause_ms;
  logic [SPEED_W-1:0] scroll_speed, rollover_speed;

  logic               v1, v2, v3, v4;
  logic               is_tick1, is_tick2, is_tick3, is_tick4;
  logic [X_W-1:0]     x1;
  logic [DELTA_W-1:0] delta1, delta2, delta3, delta4;
  logic [X_W-1:0]     elapsed_sat;
  scaled_t            ds, dr;

  phase_t             scroll_phase, phase_n;
  logic [ELAPSED_W-1:0] elapsed_ms, elapsed_add;
  logic [ELAPSED_W:0] elapsed_sum;
  pos_t               pos_s, pos_r, pos_s_add, pos_r_add, pos_s_load, pos_r_load;

  logic                active_c, trans;
  logic [TEXT_W-1:0]   overflow;
  logic [OFFSET_W-1:0] off_c;
  logic [Q_W:0]        roll_sum;
  logic [Q_W+2:0]      roll_lhs, roll_rhs;

  function automatic pos_t pos_load(input scaled_t d);
    pos_t p;
    p.r = d.rem;
    if (|d.quo[QUO_W-1:Q_W]) begin
      p.q = Q_MAX;
    end else begin
      p.q = d.quo[Q_W-1:0];
    end
    return p;
  endfunction

  function automatic pos_t pos_add(input pos_t a, input scaled_t d);
    pos_t             p;
    logic [REM_W:0]   rsum;
    logic             carry;
    logic [QUO_W:0]   qsum;
    rsum  = (REM_W+1)'(a.r) + (REM_W+1)'(d.rem);
    carry = rsum >= (REM_W+1)'(MS_PER_S);
    if (carry) begin
      rsum = rsum - (REM_W+1)'(MS_PER_S);
    end
    p.r  = rsum[REM_W-1:0];
    qsum = (QUO_W+1)'(a.q) + (QUO_W+1)'(d.quo) + (QUO_W+1)'(carry);
    if (qsum > (QUO_W+1)'(Q_MAX)) begin
      p.q = Q_MAX;
    end else begin
      p.q = qsum[Q_W-1:0];
    end
    return p;
  endfunction

  assign en         = !result_valid || !result_stall;
  assign tick_stall = !en;
  assign cfg_ready  = en && !tick_valid;
  assign tick_acc   = tick_valid && en;
  assign cfg_acc    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_width     <= '0;
      box_width      <= '0;
      pause_ms       <= '0;
      scroll_speed   <= '0;
      rollover_speed <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEXT_WIDTH:     text_width     <= cfg_data[TEXT_W-1:0];
        REG_BOX_WIDTH:      box_width      <= cfg_data[TEXT_W-1:0];
        REG_PAUSE_MS:       pause_ms       <= cfg_data[PAUSE_W-1:0];
        REG_SCROLL_SPEED:   scroll_speed   <= cfg_data[SPEED_W-1:0];
        REG_ROLLOVER_SPEED: rollover_speed <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed_sat = (|elapsed_ms[ELAPSED_W-1:X_W]) ? '1 : elapsed_ms[X_W-1:0];

  // pipeline control and payload up to the state stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= tick_acc || cfg_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_tick1 <= tick_acc;
      x1       <= tick_acc ? X_W'(delta_ms) : elapsed_sat;
      delta1   <= delta_ms;
      is_tick2 <= is_tick1;
      is_tick3 <= is_tick2;
      is_tick4 <= is_tick3;
      delta2   <= delta1;
      delta3   <= delta2;
      delta4   <= delta3;
    end
  end

  mss_scale u_scale_scroll (
    .clk   (clk),
    .en    (en),
    .x     (x1),
    .speed (scroll_speed),
    .res   (ds)
  );

  mss_scale u_scale_roll (
    .clk   (clk),
    .en    (en),
    .x     (x1),
    .speed (rollover_speed),
    .res   (dr)
  );

  always_comb begin
    active_c    = text_width > box_width;
    overflow    = text_width - box_width;
    roll_sum    = (Q_W+1)'(overflow) + (Q_W+1)'(pos_r.q);
    roll_lhs    = {roll_sum, 2'b00};
    roll_rhs    = (Q_W+3)'({text_width, 2'b00}) + (Q_W+3)'(box_width);
    elapsed_sum = (ELAPSED_W+1)'(elapsed_ms) + (ELAPSED_W+1)'(delta4);
    elapsed_add = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
    pos_s_add   = pos_add(pos_s, ds);
    pos_r_add   = pos_add(pos_r, dr);
    pos_s_load  = pos_load(ds);
    pos_r_load  = pos_load(dr);
    trans       = 1'b0;
    phase_n     = scroll_phase;
    off_c       = '0;
    unique case (scroll_phase)
      PH_LEFT_PAUSE: begin
        if (elapsed_ms > ELAPSED_W'(pause_ms)) begin
          trans   = 1'b1;
          phase_n = PH_SCROLL_RIGHT;
        end
      end
      PH_SCROLL_RIGHT: begin
        if (pos_s.q >= Q_W'(overflow)) begin
          off_c   = OFFSET_W'(overflow);
          trans   = 1'b1;
          phase_n = PH_RIGHT_PAUSE;
        end else begin
          off_c = pos_s.q;
        end
      end
      PH_RIGHT_PAUSE: begin
        off_c = OFFSET_W'(overflow);
        if (elapsed_ms > ELAPSED_W'(pause_ms)) begin
          trans   = 1'b1;
          phase_n = PH_ROLL_OVER;
        end
      end
      PH_ROLL_OVER: begin
        if (roll_lhs >= roll_rhs) begin
          trans   = 1'b1;
          phase_n = PH_LEFT_PAUSE;
        end else begin
          off_c = roll_sum[OFFSET_W-1:0];
        end
      end
    endcase
    if (!active_c) begin
      off_c   = '0;
      trans   = 1'b0;
      phase_n = scroll_phase;
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_phase <= PH_LEFT_PAUSE;
      elapsed_ms   <= '0;
      pos_s        <= '0;
      pos_r        <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v4 && is_tick4;
      if (v4 && is_tick4) begin
        offset <= off_c;
        phase  <= phase_n;
        active <= active_c;
        if (active_c) begin
          scroll_phase <= phase_n;
          if (trans) begin
            elapsed_ms <= ELAPSED_W'(delta4);
            pos_s      <= pos_s_load;
            pos_r      <= pos_r_load;
          end else begin
            elapsed_ms <= elapsed_add;
            pos_s      <= pos_s_add;
            pos_r      <= pos_r_add;
          end
        end
      end else if (v4) begin
        pos_s <= pos_s_load;
        pos_r <= pos_r_load;
      end
    end
  end

endmodule
